@@ design/afsc_pkg.sv @@
package afsc_pkg;

    localparam int POS_W        = 10;
    localparam int LONG_CNT_W   = 9;
    localparam int SHORT_CNT_W  = 6;
    localparam int SEG_IDX_W    = 11;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_IDX_W    = 1;
    localparam int FIELD_W      = 2;

    localparam int SEGMENT_LENGTH  = 832;
    localparam int LONG_PN_OFFSET  = 4;
    localparam int SHORT_PN_OFFSET = 578;
    localparam int LONG_LEN        = 511;
    localparam int SHORT_LEN       = 63;

    localparam logic [POS_W-1:0] POS_MAX     = '1;
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(SEGMENT_LENGTH - 1);
    localparam logic [POS_W-1:0] LONG_START  = POS_W'(LONG_PN_OFFSET);
    localparam logic [POS_W-1:0] LONG_END    = POS_W'(LONG_PN_OFFSET + LONG_LEN);
    localparam logic [POS_W-1:0] SHORT_START = POS_W'(SHORT_PN_OFFSET);
    localparam logic [POS_W-1:0] SHORT_END   = POS_W'(SHORT_PN_OFFSET + SHORT_LEN);

    localparam logic [LONG_CNT_W-1:0]  LONG_CNT_MAX  = '1;
    localparam logic [SHORT_CNT_W-1:0] SHORT_CNT_MAX = '1;
    localparam logic [SHORT_CNT_W-1:0] SHORT_LEN_C   = SHORT_CNT_W'(SHORT_LEN);

    // LFSR windows hold the next 9 (6) sequence bits, bit 0 is the current one
    localparam logic [8:0] LONG_SEED  = 9'b010000000;
    localparam logic [5:0] SHORT_SEED = 6'b100111;

    localparam logic [CFG_IDX_W-1:0] CFG_PN511_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PN63_LIMIT  = 1'd1;

    localparam logic [8:0] PN511_LIMIT_RST = 9'd20;
    localparam logic [4:0] PN63_LIMIT_RST  = 5'd5;

    localparam logic [FIELD_W-1:0] FIELD_NONE = 2'd0;
    localparam logic [FIELD_W-1:0] FIELD_ONE  = 2'd1;
    localparam logic [FIELD_W-1:0] FIELD_TWO  = 2'd2;

    localparam logic signed [SEG_IDX_W-1:0] SEG_SYNC = -11'sd1;
    localparam logic signed [SEG_IDX_W-1:0] SEG_MAX  = 11'sd1023;

    typedef struct packed {
        logic [LONG_CNT_W-1:0]  long_cnt;
        logic [SHORT_CNT_W-1:0] short_cnt;
        logic                   length_ok;
    } corr_t;

    typedef struct packed {
        logic                        valid;
        logic                        second_field;
        logic signed [SEG_IDX_W-1:0] segment_index;
        logic                        ambiguous_sync;
    } result_t;

endpackage

@@ design/afsc_correlator.sv @@
module afsc_correlator import afsc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  step,
    input  logic  bit_in,
    input  logic  last,
    output corr_t corr
);

    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [8:0]             long_pn_reg, long_pn_next;
    logic [5:0]             short_pn_reg, short_pn_next;
    logic [LONG_CNT_W-1:0]  long_cnt_reg, long_cnt_next;
    logic [SHORT_CNT_W-1:0] short_cnt_reg, short_cnt_next;
    logic                   in_long, in_short;
    logic                   long_fb, short_fb;
    logic [LONG_CNT_W-1:0]  long_cnt_upd;
    logic [SHORT_CNT_W-1:0] short_cnt_upd;

    assign in_long  = (pos_reg >= LONG_START) && (pos_reg < LONG_END);
    assign in_short = (pos_reg >= SHORT_START) && (pos_reg < SHORT_END);

    assign long_fb  = long_pn_reg[7] ^ long_pn_reg[6] ^ long_pn_reg[4] ^
                      long_pn_reg[3] ^ long_pn_reg[1] ^ long_pn_reg[0];
    assign short_fb = short_pn_reg[1] ^ short_pn_reg[0];

    always_comb begin
        long_cnt_upd = long_cnt_reg;
        if (in_long && (bit_in ^ long_pn_reg[0]) && long_cnt_reg != LONG_CNT_MAX)
            long_cnt_upd = long_cnt_reg + 1'b1;
        short_cnt_upd = short_cnt_reg;
        if (in_short && (bit_in ^ short_pn_reg[0]) && short_cnt_reg != SHORT_CNT_MAX)
            short_cnt_upd = short_cnt_reg + 1'b1;
    end

    assign corr.long_cnt  = long_cnt_upd;
    assign corr.short_cnt = short_cnt_upd;
    assign corr.length_ok = (pos_reg == POS_LAST);

    always_comb begin
        pos_next       = pos_reg;
        long_pn_next   = long_pn_reg;
        short_pn_next  = short_pn_reg;
        long_cnt_next  = long_cnt_reg;
        short_cnt_next = short_cnt_reg;
        if (step) begin
            if (last) begin
                pos_next       = '0;
                long_pn_next   = LONG_SEED;
                short_pn_next  = SHORT_SEED;
                long_cnt_next  = '0;
                short_cnt_next = '0;
            end else begin
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + 1'b1;
                if (in_long)
                    long_pn_next = {long_fb, long_pn_reg[8:1]};
                if (in_short)
                    short_pn_next = {short_fb, short_pn_reg[5:1]};
                long_cnt_next  = long_cnt_upd;
                short_cnt_next = short_cnt_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            long_pn_reg   <= LONG_SEED;
            short_pn_reg  <= SHORT_SEED;
            long_cnt_reg  <= '0;
            short_cnt_reg <= '0;
        end else begin
            pos_reg       <= pos_next;
            long_pn_reg   <= long_pn_next;
            short_pn_reg  <= short_pn_next;
            long_cnt_reg  <= long_cnt_next;
            short_cnt_reg <= short_cnt_next;
        end
    end

endmodule

@@ design/afsc_decision.sv @@
module afsc_decision import afsc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       seg_end,
    input  corr_t      corr,
    input  logic [8:0] pn511_limit,
    input  logic [4:0] pn63_limit,
    output result_t    result
);

    logic [FIELD_W-1:0]          field_reg, field_next;
    logic signed [SEG_IDX_W-1:0] seg_cnt_reg, seg_cnt_next;
    logic                        hit, fit_one, fit_two, ambiguous;
    logic [FIELD_W-1:0]          field_upd;
    logic signed [SEG_IDX_W-1:0] seg_cnt_upd;
    logic [SHORT_CNT_W-1:0]      inv_thresh;

    assign inv_thresh = SHORT_LEN_C - {1'b0, pn63_limit};
    assign hit        = corr.length_ok && (corr.long_cnt < pn511_limit);
    assign fit_one    = corr.short_cnt <= {1'b0, pn63_limit};
    assign fit_two    = corr.short_cnt >= inv_thresh;

    always_comb begin
        field_upd   = field_reg;
        seg_cnt_upd = seg_cnt_reg;
        ambiguous   = 1'b0;
        if (hit) begin
            if (fit_one) begin
                field_upd   = FIELD_ONE;
                seg_cnt_upd = SEG_SYNC;
            end else if (fit_two) begin
                field_upd   = FIELD_TWO;
                seg_cnt_upd = SEG_SYNC;
            end else begin
                ambiguous = 1'b1;
            end
        end
    end

    always_comb begin
        result.valid          = seg_end && (field_upd == FIELD_ONE || field_upd == FIELD_TWO);
        result.second_field   = (field_upd == FIELD_TWO);
        result.segment_index  = seg_cnt_upd;
        result.ambiguous_sync = ambiguous;

        field_next   = field_reg;
        seg_cnt_next = seg_cnt_reg;
        if (seg_end) begin
            field_next   = field_upd;
            seg_cnt_next = seg_cnt_upd;
            // counter only advances while in sync, and stops at the top
            if (result.valid && seg_cnt_upd != SEG_MAX)
                seg_cnt_next = seg_cnt_upd + 11'sd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_reg   <= FIELD_NONE;
            seg_cnt_reg <= '0;
        end else begin
            field_reg   <= field_next;
            seg_cnt_reg <= seg_cnt_next;
        end
    end

endmodule

@@ design/atsc_field_sync_checker_top.sv @@
// Field sync checker for ATSC data segments.
// Input channel (s_*): one soft symbol per transaction, with s_last_of_segment
// high on the final symbol of each segment. Only the sign of s_sample is used.
// Output channel (m_*): one transaction per segment end once field sync has been
// found, carrying the field flag, the segment index (-1 on the sync segment)
// and an ambiguity flag for a PN511 hit whose PN63 fits neither field.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index (0: PN511
// error limit, 1: PN63 error limit); write only while the block is idle.
// Throughput: one symbol per cycle while m_ready does not stall the output. The
// input register feeds the correlator and decision logic, which load the output
// register as the last symbol leaves the input register; m_valid comes from it.
// A stalled m_ready holds the output register; the input register then fills
// and s_ready drops until the result is taken.
// Reset (aresetn low, synchronous): no sync, counters cleared, limits back to
// 20 and 5, both channels empty.
module atsc_field_sync_checker_top import afsc_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [15:0]          s_sample,
    input  logic                        s_last_of_segment,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_second_field,
    output logic signed [SEG_IDX_W-1:0] m_segment_index,
    output logic                        m_ambiguous_sync,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    logic       in_valid_reg, in_bit_reg, in_last_reg;
    logic       out_valid_reg;
    logic       out_second_reg, out_ambig_reg;
    logic signed [SEG_IDX_W-1:0] out_index_reg;
    logic [8:0] pn511_limit_reg;
    logic [4:0] pn63_limit_reg;
    logic       out_ready, consume, s_fire;
    corr_t      corr;
    result_t    result;

    assign out_ready = !out_valid_reg || m_ready;
    assign consume   = in_valid_reg && out_ready;
    assign s_ready   = !in_valid_reg || consume;
    assign s_fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pn511_limit_reg <= PN511_LIMIT_RST;
            pn63_limit_reg  <= PN63_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PN511_LIMIT: pn511_limit_reg <= cfg_data;
                CFG_PN63_LIMIT:  pn63_limit_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            in_valid_reg <= 1'b0;
        else if (s_fire)
            in_valid_reg <= 1'b1;
        else if (consume)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_bit_reg  <= ~s_sample[15];
            in_last_reg <= s_last_of_segment;
        end
    end

    afsc_correlator u_corr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (consume),
        .bit_in  (in_bit_reg),
        .last    (in_last_reg),
        .corr    (corr)
    );

    afsc_decision u_dec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .seg_end     (consume && in_last_reg),
        .corr        (corr),
        .pn511_limit (pn511_limit_reg),
        .pn63_limit  (pn63_limit_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= result.valid;
    end

    always_ff @(posedge aclk) begin
        if (out_ready && result.valid) begin
            out_second_reg <= result.second_field;
            out_index_reg  <= result.segment_index;
            out_ambig_reg  <= result.ambiguous_sync;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_second_field   = out_second_reg;
    assign m_segment_index  = out_index_reg;
    assign m_ambiguous_sync = out_ambig_reg;

    // an ambiguous segment keeps the counter, which already moved past the sync
    a_ambig_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ambiguous_sync |-> m_segment_index != SEG_SYNC)
        else $error("ambiguous result carries sync segment index");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_segment_index >= SEG_SYNC)
        else $error("segment index below -1");

    a_new_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> consume && in_last_reg)
        else $error("result produced without a segment end");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled while input register empty");

endmodule

@@ dv/afsc_result_checker.sv @@
`timescale 1ns / 1ps

module afsc_result_checker import afsc_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic signed [15:0]          s_sample,
    input  logic                        s_last_of_segment,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_second_field,
    input  logic signed [SEG_IDX_W-1:0] m_segment_index,
    input  logic                        m_ambiguous_sync,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output int                          mismatch_count,
    output int                          reports_pending,
    output int                          reports_seen,
    output logic [LONG_LEN-1:0]         pn511_seq,
    output logic [SHORT_LEN-1:0]        pn63_seq
);

    typedef struct packed {
        logic                        second_field;
        logic signed [SEG_IDX_W-1:0] segment_index;
        logic                        ambiguous_sync;
    } seg_report_t;

    seg_report_t expected_reports[$];

    logic [POS_W-1:0]              sym_pos;
    logic [LONG_CNT_W-1:0]         long_miss;
    logic [SHORT_CNT_W-1:0]        short_miss;
    logic [FIELD_W-1:0]            field_now;
    logic signed [SEG_IDX_W-1:0]   seg_count;
    logic [8:0]                    long_limit;
    logic [4:0]                    short_limit;
    int                            fail_tally;
    int                            seen_tally;

    // Element i of each vector is the i-th transmitted chip; the preload
    // comes out first.
    initial begin
        int n;
        pn511_seq = '0;
        pn511_seq[7] = 1'b1;
        for (n = 0; n + 9 < LONG_LEN; n++) begin
            pn511_seq[n+9] = pn511_seq[n+7] ^ pn511_seq[n+6] ^ pn511_seq[n+4] ^
                             pn511_seq[n+3] ^ pn511_seq[n+1] ^ pn511_seq[n];
        end
        pn63_seq = '0;
        pn63_seq[2:0] = 3'b111;
        pn63_seq[5] = 1'b1;
        for (n = 0; n + 6 < SHORT_LEN; n++) begin
            pn63_seq[n+6] = pn63_seq[n+1] ^ pn63_seq[n];
        end
    end

    task automatic take_symbol(input logic signed [15:0] sample, input logic last);
        logic        sym_bit;
        logic        ambiguous;
        seg_report_t rep;
        sym_bit = ~sample[15];
        ambiguous = 1'b0;
        if (sym_pos >= LONG_PN_OFFSET && sym_pos < LONG_PN_OFFSET + LONG_LEN) begin
            if ((sym_bit ^ pn511_seq[sym_pos - LONG_PN_OFFSET]) && long_miss != LONG_CNT_MAX)
                long_miss++;
        end
        if (sym_pos >= SHORT_PN_OFFSET && sym_pos < SHORT_PN_OFFSET + SHORT_LEN) begin
            if ((sym_bit ^ pn63_seq[sym_pos - SHORT_PN_OFFSET]) && short_miss != SHORT_CNT_MAX)
                short_miss++;
        end
        if (!last) begin
            if (sym_pos != POS_MAX)
                sym_pos++;
        end else begin
            if (sym_pos == SEGMENT_LENGTH - 1 && long_miss < long_limit) begin
                if (short_miss <= short_limit) begin
                    field_now = FIELD_ONE;
                    seg_count = SEG_SYNC;
                end else if (int'(short_miss) >= SHORT_LEN - int'(short_limit)) begin
                    field_now = FIELD_TWO;
                    seg_count = SEG_SYNC;
                end else begin
                    ambiguous = 1'b1;
                end
            end
            sym_pos = '0;
            long_miss = '0;
            short_miss = '0;
            if (field_now == FIELD_ONE || field_now == FIELD_TWO) begin
                rep.second_field = (field_now == FIELD_TWO);
                rep.segment_index = seg_count;
                rep.ambiguous_sync = ambiguous;
                expected_reports.push_back(rep);
                if (seg_count < SEG_MAX)
                    seg_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        seg_report_t rep;
        if (!aresetn) begin
            sym_pos = '0;
            long_miss = '0;
            short_miss = '0;
            field_now = FIELD_NONE;
            seg_count = '0;
            long_limit = PN511_LIMIT_RST;
            short_limit = PN63_LIMIT_RST;
            expected_reports.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen_tally++;
                if (expected_reports.size() == 0) begin
                    $error("unexpected result: second_field %0d segment_index %0d ambiguous_sync %0d",
                           m_second_field, m_segment_index, m_ambiguous_sync);
                    fail_tally++;
                end else begin
                    rep = expected_reports.pop_front();
                    if (m_second_field !== rep.second_field) begin
                        $error("second_field mismatch: expected %0d, actual %0d",
                               rep.second_field, m_second_field);
                        fail_tally++;
                    end
                    if (m_segment_index !== rep.segment_index) begin
                        $error("segment_index mismatch: expected %0d, actual %0d",
                               rep.segment_index, m_segment_index);
                        fail_tally++;
                    end
                    if (m_ambiguous_sync !== rep.ambiguous_sync) begin
                        $error("ambiguous_sync mismatch: expected %0d, actual %0d",
                               rep.ambiguous_sync, m_ambiguous_sync);
                        fail_tally++;
                    end
                end
            end
            if (s_valid && s_ready)
                take_symbol(s_sample, s_last_of_segment);
            if (cfg_wr_en) begin
                if (cfg_index == CFG_PN511_LIMIT)
                    long_limit = cfg_data[8:0];
                else if (cfg_index == CFG_PN63_LIMIT)
                    short_limit = cfg_data[4:0];
            end
        end
        mismatch_count <= fail_tally;
        reports_pending <= expected_reports.size();
        reports_seen <= seen_tally;
    end

endmodule

@@ dv/atsc_field_sync_checker_top_tb.sv @@
`timescale 1ns / 1ps

module atsc_field_sync_checker_top_tb import afsc_pkg::*;;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 200;

    typedef enum logic [1:0] {PAT_RANDOM, PAT_FIELD1, PAT_FIELD2} seg_pattern_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [15:0]          s_sample;
    logic                        s_last_of_segment;
    logic                        m_valid;
    logic                        m_ready;
    logic                        m_second_field;
    logic signed [SEG_IDX_W-1:0] m_segment_index;
    logic                        m_ambiguous_sync;
    logic                        cfg_wr_en;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    int                          mismatch_count;
    int                          reports_pending;
    int                          reports_seen;
    logic [LONG_LEN-1:0]         pn511_seq;
    logic [SHORT_LEN-1:0]        pn63_seq;

    bit                          tx_idle_on = 1'b1;
    bit                          rx_idle_on = 1'b1;
    bit                          hold_req = 1'b0;
    int                          items_sent = 0;
    logic [8:0]                  long_lim_now = PN511_LIMIT_RST;
    logic [4:0]                  short_lim_now = PN63_LIMIT_RST;

    atsc_field_sync_checker_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sample(s_sample), .s_last_of_segment(s_last_of_segment),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_second_field(m_second_field), .m_segment_index(m_segment_index),
        .m_ambiguous_sync(m_ambiguous_sync),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    afsc_result_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sample(s_sample), .s_last_of_segment(s_last_of_segment),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_second_field(m_second_field), .m_segment_index(m_segment_index),
        .m_ambiguous_sync(m_ambiguous_sync),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatch_count(mismatch_count), .reports_pending(reports_pending),
        .reports_seen(reports_seen), .pn511_seq(pn511_seq), .pn63_seq(pn63_seq)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Non-negative symbols carry a 1 chip; extremes show up now and then.
    function automatic logic signed [15:0] symbol_for(input bit chip);
        logic signed [15:0] v;
        if ($urandom_range(0, 7) == 0) begin
            if (chip)
                v = $urandom_range(0, 1) ? 16'h7FFF : 16'h0000;
            else
                v = $urandom_range(0, 1) ? 16'hFFFF : 16'h8000;
        end else begin
            v = 16'($urandom);
            v[15] = ~chip;
        end
        return v;
    endfunction

    task automatic send_symbol(input logic signed [15:0] v, input logic last);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= v;
        s_last_of_segment <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // PN windows get the sequences with a given number of flipped chips;
    // field 2 inverts the PN63 window.
    task automatic send_segment(input seg_pattern_t pattern, input int length,
                                input int long_errs, input int short_errs);
        bit long_flip [LONG_LEN];
        bit short_flip [SHORT_LEN];
        bit chip;
        int k;
        int idx;
        int p;
        long_flip = '{default: 1'b0};
        short_flip = '{default: 1'b0};
        k = 0;
        while (k < long_errs) begin
            idx = $urandom_range(0, LONG_LEN - 1);
            if (!long_flip[idx]) begin
                long_flip[idx] = 1'b1;
                k++;
            end
        end
        k = 0;
        while (k < short_errs) begin
            idx = $urandom_range(0, SHORT_LEN - 1);
            if (!short_flip[idx]) begin
                short_flip[idx] = 1'b1;
                k++;
            end
        end
        for (p = 0; p < length; p++) begin
            if (pattern != PAT_RANDOM && p >= LONG_PN_OFFSET &&
                p < LONG_PN_OFFSET + LONG_LEN) begin
                chip = pn511_seq[p - LONG_PN_OFFSET] ^ long_flip[p - LONG_PN_OFFSET];
            end else if (pattern != PAT_RANDOM && p >= SHORT_PN_OFFSET &&
                         p < SHORT_PN_OFFSET + SHORT_LEN) begin
                chip = pn63_seq[p - SHORT_PN_OFFSET] ^ short_flip[p - SHORT_PN_OFFSET] ^
                       (pattern == PAT_FIELD2);
            end else begin
                chip = 1'($urandom_range(0, 1));
            end
            send_symbol(symbol_for(chip), p == length - 1);
        end
    endtask

    // The extra wait after the queue empties covers segments that end in no result.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (reports_pending != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_limits(input logic [8:0] long_lim, input logic [4:0] short_lim);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PN511_LIMIT;
        cfg_data <= long_lim;
        @(posedge aclk);
        cfg_index <= CFG_PN63_LIMIT;
        cfg_data <= {4'($urandom_range(0, 15)), short_lim};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        long_lim_now = long_lim;
        short_lim_now = short_lim;
    endtask

    initial begin
        int stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            stall = rx_idle_on ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid && !hold_req);
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        seg_pattern_t pattern;
        int seg_n;
        int first_report;
        int kind_sel;
        int seg_len;
        int long_errs;
        int short_errs;
        int lim_cap;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_sample <= '0;
        s_last_of_segment <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_PN511_LIMIT;
        cfg_data <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no sync yet: nothing comes out, not even for an ambiguous PN63
        send_segment(PAT_RANDOM, 5, 0, 0);
        send_segment(PAT_FIELD1, SEGMENT_LENGTH, 0, 10);
        // field 1 right at both limits
        send_segment(PAT_FIELD1, SEGMENT_LENGTH, 19, 5);
        send_segment(PAT_RANDOM, 1, 0, 0);
        send_segment(PAT_FIELD1, SEGMENT_LENGTH, 20, 0);
        // wrong lengths, then a segment whose flag comes past position 1023
        send_segment(PAT_FIELD1, SEGMENT_LENGTH - 1, 0, 0);
        send_segment(PAT_FIELD1, SEGMENT_LENGTH + 1, 0, 0);
        send_segment(PAT_RANDOM, 1100, 0, 0);
        send_segment(PAT_FIELD2, SEGMENT_LENGTH, 0, 5);
        send_segment(PAT_FIELD1, SEGMENT_LENGTH, 0, 6);
        send_segment(PAT_FIELD2, SEGMENT_LENGTH, 0, 6);
        send_segment(PAT_FIELD1, SEGMENT_LENGTH, 0, 0);

        drain_results();
        write_limits(9'd0, 5'd31);
        send_segment(PAT_FIELD2, SEGMENT_LENGTH, 0, 0);

        drain_results();
        write_limits(9'd1, 5'd0);
        send_segment(PAT_FIELD2, SEGMENT_LENGTH, 0, 0);
        send_segment(PAT_FIELD1, SEGMENT_LENGTH, 0, 1);
        send_segment(PAT_FIELD1, SEGMENT_LENGTH, 1, 0);
        send_segment(PAT_FIELD1, SEGMENT_LENGTH, 0, 0);

        drain_results();
        write_limits(9'd511, 5'd31);
        send_segment(PAT_FIELD1, SEGMENT_LENGTH, 510, 31);
        send_segment(PAT_FIELD1, SEGMENT_LENGTH, 511, 32);
        send_segment(PAT_FIELD2, SEGMENT_LENGTH, 300, 31);

        // back-to-back one-symbol segments run the index into saturation;
        // the receiver holds off first so the block backs up
        drain_results();
        write_limits(9'd20, 5'd5);
        send_segment(PAT_FIELD1, SEGMENT_LENGTH, 0, 0);
        hold_req = 1'b1;
        tx_idle_on = 1'b0;
        repeat (1030) send_segment(PAT_RANDOM, 1, 0, 0);
        tx_idle_on = 1'b1;
        drain_results();

        first_report = reports_seen;
        items_sent = 0;
        seg_n = 0;
        while ((items_sent < 850 || reports_seen - first_report < 60) && seg_n < 400) begin
            if (seg_n % 8 == 0) begin
                drain_results();
                case ($urandom_range(0, 5))
                    0:       long_errs = 0;
                    1:       long_errs = 1;
                    2:       long_errs = 511;
                    default: long_errs = $urandom_range(1, 40);
                endcase
                case ($urandom_range(0, 3))
                    0:       short_errs = 0;
                    1:       short_errs = 31;
                    default: short_errs = $urandom_range(0, 31);
                endcase
                write_limits(9'(long_errs), 5'(short_errs));
            end
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);

            kind_sel = $urandom_range(0, 19);
            if (kind_sel < 4)
                pattern = PAT_FIELD1;
            else if (kind_sel < 6)
                pattern = PAT_FIELD2;
            else
                pattern = PAT_RANDOM;
            if (kind_sel < 7)
                seg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(SEGMENT_LENGTH - 3,
                          SEGMENT_LENGTH + 3) : SEGMENT_LENGTH;
            else
                seg_len = $urandom_range(1, 40);

            lim_cap = (long_lim_now + 2 > LONG_LEN) ? LONG_LEN : long_lim_now + 2;
            long_errs = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, lim_cap);
            case ($urandom_range(0, 2))
                0:       short_errs = $urandom_range(0, short_lim_now + 1);
                1:       short_errs = $urandom_range(0, SHORT_LEN);
                default: short_errs = $urandom_range(SHORT_LEN - 1 - short_lim_now, SHORT_LEN);
            endcase
            send_segment(pattern, seg_len, long_errs, short_errs);
            seg_n++;
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (reports_pending != 0);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && reports_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
